[hw/rtl/multi_voice_biquad_filter_top_assert.svh]
// ============================================================================
// Assertion macros for the multi-voice biquad filter
// Shared shorthand for the concurrent assertions of the block's checker.
// ============================================================================
`ifndef MULTI_VOICE_BIQUAD_FILTER_TOP_ASSERT_SVH
`define MULTI_VOICE_BIQUAD_FILTER_TOP_ASSERT_SVH

// Condition and consequence in the same cycle.
`define MVBQ_ASSERT_NOW(lbl, clk, dis, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define MVBQ_ASSERT_NEXT(lbl, clk, dis, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
      else $error(msg);

`endif

[hw/rtl/mvbq_pkg.sv]
// ============================================================================
// Multi-voice biquad filter package
// Widths, types, register indexes and constants shared by the filter modules.
// ============================================================================
`timescale 1ns / 1ps

package mvbq_pkg;

   localparam int NUM_VOICES   = 16;
   localparam int SAMPLE_W     = 24;
   localparam int VOICE_W      = 4;
   localparam int COEF_W       = 32;
   localparam int COEF_FRAC    = 28;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int PIPE_STAGES  = 3;

   // Voice index into the history store; the voice field must cover it.
   localparam int VOICE_ADDR_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   // Product, partial sum and full sum widths of the multiply-accumulate path.
   localparam int PROD_W = COEF_W + SAMPLE_W;
   localparam int PSUM_W = PROD_W + 2;
   localparam int SUM_W  = PROD_W + 3;
   localparam int RND_W  = SUM_W - COEF_FRAC;

   localparam logic [VOICE_W:0] VOICE_LIMIT = (VOICE_W + 1)'(NUM_VOICES);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(64'd1 << (COEF_FRAC - 1));
   localparam coef_type COEF_ONE = coef_type'(64'd1 << COEF_FRAC);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_B0 = 3'd0,
      CSR_COEF_B1 = 3'd1,
      CSR_COEF_B2 = 3'd2,
      CSR_COEF_A1 = 3'd3,
      CSR_COEF_A2 = 3'd4,
      CSR_BYPASS  = 3'd5
   } csr_index_type;

   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type a1;
      coef_type a2;
      logic     bypass;
   } coef_set_type;

   // One voice's history: the last two inputs and the last two outputs.
   typedef struct packed {
      sample_type in_1;
      sample_type in_2;
      sample_type out_1;
      sample_type out_2;
   } hist_type;

   localparam int HIST_W = $bits(hist_type);

   // Voices held by the pipeline stages, for the same-voice interlock.
   typedef struct packed {
      logic [PIPE_STAGES-1:0]              busy;
      logic [PIPE_STAGES-1:0][VOICE_W-1:0] voice;
   } pipe_status_type;

   typedef struct packed {
      logic                    en;
      logic [VOICE_ADDR_W-1:0] addr;
      hist_type                data;
   } hist_wb_type;

endpackage

[hw/rtl/mvbq_ram.sv]
// ============================================================================
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ============================================================================
`timescale 1ns / 1ps

module mvbq_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                     wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                     rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mvbq_csr.sv]
// ============================================================================
// Multi-voice biquad filter configuration registers
// Holds the five coefficients and the bypass switch written over the CSR port.
// ============================================================================
`timescale 1ns / 1ps

module mvbq_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [mvbq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mvbq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mvbq_pkg::coef_set_type             coefs
);

   import mvbq_pkg::*;

   coef_set_type coefs_ff;
   coef_set_type coefs_in;
   coef_type     wcoef;

   assign wcoef = $signed(csr_wdata[COEF_W-1:0]);

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_COEF_B0: coefs_in.b0     = wcoef;
            CSR_COEF_B1: coefs_in.b1     = wcoef;
            CSR_COEF_B2: coefs_in.b2     = wcoef;
            CSR_COEF_A1: coefs_in.a1     = wcoef;
            CSR_COEF_A2: coefs_in.a2     = wcoef;
            CSR_BYPASS:  coefs_in.bypass = csr_wdata[0];
            default:     coefs_in        = coefs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.b0     <= COEF_ONE;
         coefs_ff.b1     <= '0;
         coefs_ff.b2     <= '0;
         coefs_ff.a1     <= '0;
         coefs_ff.a2     <= '0;
         coefs_ff.bypass <= 1'b0;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   assign coefs = coefs_ff;

endmodule

[hw/rtl/mvbq_pipe.sv]
// ============================================================================
// Multi-voice biquad filter arithmetic pipeline
// Multiplies, sums, rounds and saturates one sample a cycle unless a stalled
// response fills the pipe, and returns its voice's updated history for write-back.
// ============================================================================
`timescale 1ns / 1ps

module mvbq_pipe (
   input  logic                              clock,
   input  logic                              reset,
   input  mvbq_pkg::coef_set_type            coefs,
   input  logic                              load,
   input  logic [mvbq_pkg::VOICE_W-1:0]      load_voice,
   input  mvbq_pkg::sample_type              load_sample,
   input  logic                              load_active,
   input  mvbq_pkg::hist_type                hist_rd,
   input  logic                              hist_ok,
   output logic                              load_ready,
   output mvbq_pkg::pipe_status_type         status,
   output mvbq_pkg::hist_wb_type             wb,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mvbq_pkg::VOICE_W-1:0]      rsp_voice_id,
   output mvbq_pkg::sample_type              rsp_sample_out,
   output logic                              rsp_saturated
);

   import mvbq_pkg::*;

   // Stage 1: waits for the history read.
   logic                     v1_ff, act1_ff;
   logic [VOICE_W-1:0]       voice1_ff;
   sample_type               x1_ff;
   // Stage 2: registered products.
   logic                     v2_ff, act2_ff;
   logic [VOICE_W-1:0]       voice2_ff;
   sample_type               x2_ff, hin2_ff, hout2_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in, p3_in, p4_in;
   // Stage 3: feedforward and feedback partial sums.
   logic                     v3_ff, act3_ff;
   logic [VOICE_W-1:0]       voice3_ff;
   sample_type               x3_ff, hin3_ff, hout3_ff;
   logic signed [PSUM_W-1:0] pos3_ff, neg3_ff;
   // Result register.
   logic                     rv_ff, rsat_ff;
   logic [VOICE_W-1:0]       rvoice_ff;
   sample_type               rsample_ff;

   hist_type                 hist_eff;
   logic                     adv1, adv2, adv3, out_free;
   logic signed [SUM_W-1:0]  total;
   logic signed [RND_W-1:0]  rounded;
   logic                     ovf;
   sample_type               y_sat;

   assign out_free = !rv_ff || rsp_ready;
   assign adv3     = v3_ff && out_free;
   assign adv2     = v2_ff && (!v3_ff || out_free);
   assign adv1     = v1_ff && (!v2_ff || !v3_ff || out_free);
   assign load_ready = !v1_ff || !v2_ff || !v3_ff || out_free;

   // A voice never written since reset reads as cleared history.
   assign hist_eff = hist_ok ? hist_rd : '0;

   assign p0_in = PROD_W'(coefs.b0) * PROD_W'(x1_ff);
   assign p1_in = PROD_W'(coefs.b1) * PROD_W'(hist_eff.in_1);
   assign p2_in = PROD_W'(coefs.b2) * PROD_W'(hist_eff.in_2);
   assign p3_in = PROD_W'(coefs.a1) * PROD_W'(hist_eff.out_1);
   assign p4_in = PROD_W'(coefs.a2) * PROD_W'(hist_eff.out_2);

   // Round half up at sample scale, then clip to the sample range.
   assign total   = SUM_W'(pos3_ff) - SUM_W'(neg3_ff) + ROUND_BIAS;
   assign rounded = total[SUM_W-1:COEF_FRAC];
   assign ovf     = rounded[RND_W-1:SAMPLE_W-1] != {(RND_W - SAMPLE_W + 1){rounded[RND_W-1]}};
   assign y_sat   = ovf ? (rounded[RND_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                        : rounded[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         if (load) begin
            v1_ff <= 1'b1;
         end else if (adv1) begin
            v1_ff <= 1'b0;
         end
         if (adv1) begin
            v2_ff <= 1'b1;
         end else if (adv2) begin
            v2_ff <= 1'b0;
         end
         if (adv2) begin
            v3_ff <= 1'b1;
         end else if (adv3) begin
            v3_ff <= 1'b0;
         end
         if (adv3) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         act1_ff   <= load_active;
         voice1_ff <= load_voice;
         x1_ff     <= load_sample;
      end
      if (adv1) begin
         act2_ff   <= act1_ff;
         voice2_ff <= voice1_ff;
         x2_ff     <= x1_ff;
         hin2_ff   <= hist_eff.in_1;
         hout2_ff  <= hist_eff.out_1;
         p0_ff     <= p0_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         p3_ff     <= p3_in;
         p4_ff     <= p4_in;
      end
      if (adv2) begin
         act3_ff   <= act2_ff;
         voice3_ff <= voice2_ff;
         x3_ff     <= x2_ff;
         hin3_ff   <= hin2_ff;
         hout3_ff  <= hout2_ff;
         pos3_ff   <= PSUM_W'(p0_ff) + PSUM_W'(p1_ff) + PSUM_W'(p2_ff);
         neg3_ff   <= PSUM_W'(p3_ff) + PSUM_W'(p4_ff);
      end
      if (adv3) begin
         rvoice_ff  <= voice3_ff;
         rsample_ff <= act3_ff ? y_sat : x3_ff;
         rsat_ff    <= act3_ff && ovf;
      end
   end

   assign wb.en            = adv3 && act3_ff;
   assign wb.addr          = voice3_ff[VOICE_ADDR_W-1:0];
   assign wb.data.in_1     = x3_ff;
   assign wb.data.in_2     = hin3_ff;
   assign wb.data.out_1    = y_sat;
   assign wb.data.out_2    = hout3_ff;

   assign status.busy  = {v3_ff && act3_ff, v2_ff && act2_ff, v1_ff && act1_ff};
   assign status.voice = {voice3_ff, voice2_ff, voice1_ff};

   assign rsp_valid      = rv_ff;
   assign rsp_voice_id   = rvoice_ff;
   assign rsp_sample_out = rsample_ff;
   assign rsp_saturated  = rsat_ff;

endmodule

[hw/rtl/multi_voice_biquad_filter_top.sv]
// ============================================================================
// Multi-voice biquad filter
// Direct-form-I biquad with a separate history for each of sixteen voices.
// ============================================================================
// The block filters a stream of signed Q1.23 samples, each tagged with a voice
// number, through a direct-form-I biquad whose five Q4.28 coefficients are
// shared by all voices, while each voice keeps its own two past inputs and two
// past outputs. A result beat passes through pipeline stages 1, 2 and 3 and the
// result register after its request beat is accepted, and leaves in request
// order. One request beat can be accepted every cycle as long as a filtered
// beat does not share its voice with any filtered beat still in the three-stage
// arithmetic pipeline. A filtered beat for such a voice is held off until the
// earlier beat has written its history back; the recursion through the feedback
// multiply, sum and write-back of the history memory sets that limit. Bypassed
// beats pass through the same pipeline and are never held off by this
// interlock; they wait only while a stalled response has filled the pipeline.
// History starts cleared after reset with no clearing pass: a valid flag per
// voice makes an unwritten voice read as zero. Configuration is to be written
// by the user only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps

module multi_voice_biquad_filter_top (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mvbq_pkg::VOICE_W-1:0]       req_voice_id,
   input  logic signed [mvbq_pkg::SAMPLE_W-1:0] req_sample_in,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mvbq_pkg::VOICE_W-1:0]       rsp_voice_id,
   output logic signed [mvbq_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                               rsp_saturated,
   // Configuration write port.
   input  logic                               csr_write_en,
   input  logic [mvbq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mvbq_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import mvbq_pkg::*;

   coef_set_type              coefs;
   pipe_status_type           status;
   hist_wb_type               wb;
   hist_type                  hist_rd;
   logic [HIST_W-1:0]         hist_rd_raw;
   logic                      pipe_ready;
   logic                      in_active;
   logic                      hazard;
   logic                      accept;
   logic [VOICE_ADDR_W-1:0]   rd_addr;
   // One flag per voice: set once its history has been written since reset.
   logic [NUM_VOICES-1:0]     hist_ok_ff;
   logic                      hist_ok_rd_ff;

   mvbq_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .coefs        (coefs)
   );

   // A beat is filtered unless bypass is on or its voice lies outside the
   // history store; only filtered beats read and write history.
   assign in_active = !coefs.bypass && ({1'b0, req_voice_id} < VOICE_LIMIT);
   assign rd_addr   = req_voice_id[VOICE_ADDR_W-1:0];

   // Interlock: a filtered beat may not enter while a filtered beat of the
   // same voice is anywhere before write-back, as its history is not final.
   always_comb begin
      hazard = 1'b0;
      for (int s = 0; s < PIPE_STAGES; s++) begin
         if (status.busy[s] && (status.voice[s] == req_voice_id)) begin
            hazard = in_active;
         end
      end
   end

   assign req_ready = pipe_ready && !hazard;
   assign accept    = req_valid && req_ready;

   mvbq_ram #(
      .DATA_W (HIST_W),
      .DEPTH  (NUM_VOICES)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wb.en),
      .wr_addr (wb.addr),
      .wr_data (wb.data),
      .rd_en   (accept && in_active),
      .rd_addr (rd_addr),
      .rd_data (hist_rd_raw)
   );

   assign hist_rd = hist_rd_raw;

   // The flag is sampled alongside the memory read, so both hold together
   // while the first stage is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ok_ff <= '0;
      end else if (wb.en) begin
         hist_ok_ff[wb.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_active) begin
         hist_ok_rd_ff <= hist_ok_ff[rd_addr];
      end
   end

   mvbq_pipe u_pipe (
      .clock          (clock),
      .reset          (reset),
      .coefs          (coefs),
      .load           (accept),
      .load_voice     (req_voice_id),
      .load_sample    (req_sample_in),
      .load_active    (in_active),
      .hist_rd        (hist_rd),
      .hist_ok        (hist_ok_rd_ff),
      .load_ready     (pipe_ready),
      .status         (status),
      .wb             (wb),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_voice_id   (rsp_voice_id),
      .rsp_sample_out (rsp_sample_out),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

[hw/rtl/mvbq_checker.sv]
// ============================================================================
// Multi-voice biquad filter port checker
// Watches the top-level ports for reset, stall, saturation and interlock rules.
// ============================================================================
`timescale 1ns / 1ps
`include "multi_voice_biquad_filter_top_assert.svh"

module mvbq_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [mvbq_pkg::VOICE_W-1:0]         req_voice_id,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [mvbq_pkg::VOICE_W-1:0]         rsp_voice_id,
   input  logic signed [mvbq_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                 rsp_saturated,
   input  logic                                 csr_write_en,
   input  logic [mvbq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mvbq_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import mvbq_pkg::*;

   logic               bypass_ff;
   logic               acc_ff;
   logic               acc_active_ff;
   logic [VOICE_W-1:0] acc_voice_ff;

   // Shadow of the bypass switch, and the previous accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
         acc_ff    <= 1'b0;
      end else begin
         if (csr_write_en && (csr_index == CSR_BYPASS)) begin
            bypass_ff <= csr_wdata[0];
         end
         acc_ff <= req_valid && req_ready;
      end
   end

   always_ff @(posedge clock) begin
      acc_voice_ff  <= req_voice_id;
      acc_active_ff <= !bypass_ff && ({1'b0, req_voice_id} < VOICE_LIMIT);
   end

   `MVBQ_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid,
      "response valid after reset")

   `MVBQ_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_sample_out) && $stable(rsp_voice_id) && $stable(rsp_saturated),
      "stalled response beat changed")

   `MVBQ_ASSERT_NOW(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated,
      (rsp_sample_out == SAMPLE_MAX) || (rsp_sample_out == SAMPLE_MIN),
      "saturated beat not at a range limit")

   `MVBQ_ASSERT_NOW(a_same_voice_held, clock, reset,
      acc_ff && acc_active_ff && !bypass_ff && req_valid && (req_voice_id == acc_voice_ff),
      !req_ready, "filtered beat of an in-flight voice accepted")

endmodule

bind multi_voice_biquad_filter_top mvbq_checker u_mvbq_checker (.*);
